/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* sv/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared widths, codes and types of the lifo stack
// ----------------------------------------------------------------------------
package lfs_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int DATA_W        = 32;
	localparam int CNT_W         = 7;
	localparam int ACT_W         = 2;
	localparam int STAT_W        = 2;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_DEPTH = 2'd3;

	// per-item result fields known at acceptance
	typedef struct packed {
		logic              use_mem;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
		logic              empty;
		logic              full;
	} meta_t;

endpackage

/* sv/lfs_if.sv */
// ----------------------------------------------------------------------------
// lfs_req_if / lfs_rsp_if
// Valid/ready channels for stack requests and results
// ----------------------------------------------------------------------------
interface lfs_req_if;
	logic                              valid;
	logic                              ready;
	logic [lfs_pkg::ACT_W-1:0]         action;
	logic signed [lfs_pkg::DATA_W-1:0] push_value;
	logic [lfs_pkg::CNT_W-1:0]         peek_depth;

	modport source (output valid, output action, output push_value, output peek_depth,
		input ready);
	modport sink (input valid, input action, input push_value, input peek_depth,
		output ready);
endinterface

interface lfs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [lfs_pkg::DATA_W-1:0] read_value;
	logic [lfs_pkg::STAT_W-1:0]        status;
	logic [lfs_pkg::CNT_W-1:0]         entry_count;
	logic                              is_empty;
	logic                              is_full;

	modport source (output valid, output read_value, output status, output entry_count,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		input is_empty, input is_full, output ready);
endinterface

/* sv/lfs_ram.sv */
// ----------------------------------------------------------------------------
// lfs_ram
// Single-port synchronous ram holding the stack entries, registered read
// ----------------------------------------------------------------------------
module lfs_ram #(
	parameter int DEPTH = lfs_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [AW-1:0]               addr,
	input  logic [lfs_pkg::DATA_W-1:0]  wdata,
	output logic [lfs_pkg::DATA_W-1:0]  rdata
);

	logic [lfs_pkg::DATA_W-1:0] mem [DEPTH];
	logic [lfs_pkg::DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/lfs_ctrl.sv */
// ----------------------------------------------------------------------------
// lfs_ctrl
// Fill count, capacity limit and per-transaction decode of ram access
// ----------------------------------------------------------------------------
module lfs_ctrl #(
	parameter int DEPTH = lfs_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lfs_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                         accept,
	input  logic [lfs_pkg::ACT_W-1:0]    action,
	input  logic [lfs_pkg::CNT_W-1:0]    peek_depth,
	output logic                         mem_we,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_addr,
	output lfs_pkg::meta_t               meta
);

	localparam int CNT_MAX = (1 << lfs_pkg::CNT_W) - 1;
	localparam int CAP_MAX = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

	logic [lfs_pkg::CNT_W-1:0]    count_q;
	logic [lfs_pkg::CNT_W-1:0]    limit_q;
	logic [lfs_pkg::CNT_W-1:0]    cap;
	logic [lfs_pkg::CNT_W-1:0]    count_nxt;
	logic [lfs_pkg::CNT_W-1:0]    addr_cnt;
	logic [lfs_pkg::CNT_W+AW-1:0] addr_ext;
	logic                         wr;
	logic                         rd;
	logic [lfs_pkg::STAT_W-1:0]   status;

	// capacity saturates at the ram depth, or at the count maximum if that is lower
	assign cap = (32'(limit_q) > CAP_MAX) ? lfs_pkg::CNT_W'(CAP_MAX) : limit_q;

	// decode of one transaction
	always_comb begin
		wr        = 1'b0;
		rd        = 1'b0;
		status    = lfs_pkg::ST_OK;
		count_nxt = count_q;
		addr_cnt  = count_q;
		case (action)
			lfs_pkg::ACT_PUSH: begin
				if (count_q >= cap) begin
					status = lfs_pkg::ST_OVERFLOW;
				end else begin
					wr        = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			lfs_pkg::ACT_POP: begin
				if (count_q == '0) begin
					status = lfs_pkg::ST_UNDERFLOW;
				end else begin
					rd        = 1'b1;
					count_nxt = count_q - 1'b1;
					addr_cnt  = count_q - 1'b1;
				end
			end
			lfs_pkg::ACT_PEEK: begin
				if (peek_depth == '0 || peek_depth > count_q) begin
					status = lfs_pkg::ST_BAD_DEPTH;
				end else begin
					rd       = 1'b1;
					addr_cnt = count_q - peek_depth;
				end
			end
			default: begin
				status = lfs_pkg::ST_OK;
			end
		endcase
	end

	// address fitted to the ram width
	assign addr_ext = {{AW{1'b0}}, addr_cnt};
	assign mem_addr = addr_ext[AW-1:0];
	assign mem_we   = accept & wr;
	assign mem_re   = accept & rd;

	assign meta.use_mem = rd;
	assign meta.status  = status;
	assign meta.count   = count_nxt;
	assign meta.empty   = (count_nxt == '0);
	assign meta.full    = (count_nxt >= cap);

	// count and limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= lfs_pkg::LIMIT_RESET;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

endmodule

/* sv/lifo_stack_with_peek.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_peek
// Stack of signed words with push, pop and peek at a depth below the top
// ----------------------------------------------------------------------------
// a result passes through stage 1 (ram read) into the stage 2 output register
// throughput: one transaction per cycle while the result side does not stall, each using the single ram port once
// a read issued at acceptance always sees the write of the previous cycle
// reset: fill count 0, limit 64, pipeline empty; ram contents stay undefined
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_with_peek #(
	parameter int DEPTH = lfs_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lfs_req_if.sink                   req,
	lfs_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [lfs_pkg::CNT_W-1:0] cfg_wdata
);

	localparam int AW      = $clog2(DEPTH);
	localparam int CNT_MAX = (1 << lfs_pkg::CNT_W) - 1;
	localparam int CAP_MAX = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

	logic                        accept;
	logic                        mem_we;
	logic                        mem_re;
	logic [AW-1:0]               mem_addr;
	logic [lfs_pkg::DATA_W-1:0]  rdata;
	lfs_pkg::meta_t              meta;
	lfs_pkg::meta_t              meta_s1;
	logic                        valid_s1;
	logic                        adv_s1;
	logic                        valid_s2;
	lfs_pkg::meta_t              meta_s2;
	logic [lfs_pkg::DATA_W-1:0]  value_s2;

	// handshake: stage 1 drains into the output register
	assign adv_s1    = valid_s1 & (~valid_s2 | rsp.ready);
	assign req.ready = ~valid_s1 | adv_s1;
	assign accept    = req.valid & req.ready;

	lfs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.action     (req.action),
		.peek_depth (req.peek_depth),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.meta       (meta)
	);

	lfs_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (req.push_value),
		.rdata (rdata)
	);

	// stage 1: ram read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			meta_s2  <= meta_s1;
			value_s2 <= meta_s1.use_mem ? rdata : '1;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.read_value  = value_s2;
	assign rsp.status      = meta_s2.status;
	assign rsp.entry_count = meta_s2.count;
	assign rsp.is_empty    = meta_s2.empty;
	assign rsp.is_full     = meta_s2.full;

	// checks
	`ASSERT_PROP(a_accept_fills_s1, clk, arst_n, accept |=> valid_s1, "accepted transaction lost")
	`ASSERT_PROP(a_err_no_word, clk, arst_n, (rsp.valid && rsp.status != lfs_pkg::ST_OK) |-> (rsp.read_value == '1), "error result carries a word")
	`ASSERT_NEVER(a_count_bound, clk, arst_n, rsp.valid && (32'(rsp.entry_count) > CAP_MAX), "entry count beyond ram depth")

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lifo stack with peek: a short directed script
// of pushes, pops, peeks and capacity changes, then phases of random
// transactions under varying limits, with random gaps on both channels. A
// shadow stack, or a typed expectation from the script, gives every result, checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = lfs_pkg::DEPTH_DEFAULT;
	localparam logic [lfs_pkg::ACT_W-1:0] ACT_NOP = 2'd3;
	localparam logic signed [lfs_pkg::DATA_W-1:0] NO_WORD = -32'sd1;
	localparam int NUM_PHASES = 13;
	localparam int PHASE_OPS = 100;

	typedef struct packed {
		logic signed [lfs_pkg::DATA_W-1:0] value;
		logic [lfs_pkg::STAT_W-1:0]        status;
		logic [lfs_pkg::CNT_W-1:0]         count;
		logic                              empty;
		logic                              full;
	} stack_result_t;

	typedef struct {
		bit                                is_limit;
		logic [lfs_pkg::CNT_W-1:0]         limit;
		logic [lfs_pkg::ACT_W-1:0]         action;
		logic signed [lfs_pkg::DATA_W-1:0] word;
		logic [lfs_pkg::CNT_W-1:0]         depth;
		bit                                typed;
		stack_result_t                     exp;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lfs_pkg::CNT_W-1:0] cfg_wdata;

	lfs_req_if req_ch ();
	lfs_rsp_if rsp_ch ();

	lifo_stack_with_peek dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow stack
	logic signed [lfs_pkg::DATA_W-1:0] stack_words [STACK_DEPTH];
	int                                stack_fill = 0;
	logic [lfs_pkg::CNT_W-1:0]         cap_limit = lfs_pkg::LIMIT_RESET;

	stack_result_t pending_results [$];
	script_row_t   script_rows [$];
	int            err_count = 0;
	bit            no_idle = 1'b0;

	// typed expectation travelling with the current request
	bit            drv_typed = 1'b0;
	stack_result_t drv_exp = '0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow stack update for one accepted transaction
	function automatic stack_result_t predict_stack_op(logic [lfs_pkg::ACT_W-1:0] act,
		logic signed [lfs_pkg::DATA_W-1:0] word, logic [lfs_pkg::CNT_W-1:0] depth);
		stack_result_t r;
		int cap;
		cap = (int'(cap_limit) > STACK_DEPTH) ? STACK_DEPTH : int'(cap_limit);
		r.value = NO_WORD;
		r.status = lfs_pkg::ST_OK;
		case (act)
			lfs_pkg::ACT_PUSH: begin
				if (stack_fill >= cap) begin
					r.status = lfs_pkg::ST_OVERFLOW;
				end else begin
					stack_words[stack_fill] = word;
					stack_fill++;
				end
			end
			lfs_pkg::ACT_POP: begin
				if (stack_fill == 0) begin
					r.status = lfs_pkg::ST_UNDERFLOW;
				end else begin
					stack_fill--;
					r.value = stack_words[stack_fill];
				end
			end
			lfs_pkg::ACT_PEEK: begin
				if (depth == 0 || int'(depth) > stack_fill)
					r.status = lfs_pkg::ST_BAD_DEPTH;
				else
					r.value = stack_words[stack_fill - int'(depth)];
			end
			default: ;
		endcase
		r.count = lfs_pkg::CNT_W'(stack_fill);
		r.empty = (stack_fill == 0);
		r.full = (stack_fill >= cap);
		return r;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic void add_op(logic [lfs_pkg::ACT_W-1:0] act,
		logic signed [lfs_pkg::DATA_W-1:0] word, logic [lfs_pkg::CNT_W-1:0] depth,
		bit typed, stack_result_t exp);
		script_row_t row;
		row.is_limit = 1'b0;
		row.limit = '0;
		row.action = act;
		row.word = word;
		row.depth = depth;
		row.typed = typed;
		row.exp = exp;
		script_rows.push_back(row);
	endfunction

	function automatic void add_limit(logic [lfs_pkg::CNT_W-1:0] lim);
		script_row_t row;
		row = '{1'b1, lim, ACT_NOP, '0, '0, 1'b0, '0};
		script_rows.push_back(row);
	endfunction

	task automatic report_field(string name, logic [lfs_pkg::DATA_W-1:0] want,
		logic [lfs_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			err_count++;
		end
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_op(logic [lfs_pkg::ACT_W-1:0] act,
		logic signed [lfs_pkg::DATA_W-1:0] word, logic [lfs_pkg::CNT_W-1:0] depth,
		bit typed, stack_result_t exp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.push_value = word;
		req_ch.peek_depth = depth;
		drv_typed = typed;
		drv_exp = exp;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// limit changes only with nothing in flight
	task automatic set_limit(logic [lfs_pkg::CNT_W-1:0] lim);
		req_ch.valid = 1'b0;
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = lim;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// result checking and prediction at the rising edge
	always @(posedge clk) begin : monitor
		stack_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result transaction with none pending, actual %h %h",
						$time, rsp_ch.read_value, rsp_ch.status);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					report_field("read_value", want.value, rsp_ch.read_value);
					report_field("status", lfs_pkg::DATA_W'(want.status),
						lfs_pkg::DATA_W'(rsp_ch.status));
					report_field("entry_count", lfs_pkg::DATA_W'(want.count),
						lfs_pkg::DATA_W'(rsp_ch.entry_count));
					report_field("is_empty", lfs_pkg::DATA_W'(want.empty),
						lfs_pkg::DATA_W'(rsp_ch.is_empty));
					report_field("is_full", lfs_pkg::DATA_W'(want.full),
						lfs_pkg::DATA_W'(rsp_ch.is_full));
				end
			end
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
				want = predict_stack_op(req_ch.action, req_ch.push_value, req_ch.peek_depth);
				if (drv_typed)
					want = drv_exp;
				pending_results.push_back(want);
			end
			if (cfg_we)
				cap_limit = cfg_wdata;
		end
	end

	// result side: random stalls
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				stall--;
			end else begin
				rsp_ch.ready = 1'b1;
				stall = pick_gap();
			end
		end
	end

	// run limit
	initial begin
		#5ms;
		$display("lifo_stack_with_peek: mismatch");
		$finish;
	end

	// stimulus
	initial begin
		int phase_limits [NUM_PHASES];
		logic [lfs_pkg::CNT_W-1:0] lim;
		logic [lfs_pkg::ACT_W-1:0] act;
		logic signed [lfs_pkg::DATA_W-1:0] word;
		logic [lfs_pkg::CNT_W-1:0] depth;
		int r;
		int push_cut;
		int pop_cut;

		phase_limits = '{64, 127, 1, 0, 8, 64, 0, 2, 100, 64, 33, 127, 5};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.action = lfs_pkg::ACT_PUSH;
		req_ch.push_value = '0;
		req_ch.peek_depth = '0;

		// directed script, limit starts at its reset value
		add_op(lfs_pkg::ACT_POP, 0, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_UNDERFLOW, 7'd0, 1'b1, 1'b0});
		add_op(lfs_pkg::ACT_PEEK, 0, 1, 1'b1,
			'{NO_WORD, lfs_pkg::ST_BAD_DEPTH, 7'd0, 1'b1, 1'b0});
		add_op(lfs_pkg::ACT_PUSH, 32'h7FFFFFFF, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OK, 7'd1, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PUSH, 32'h80000000, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OK, 7'd2, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PEEK, 0, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_BAD_DEPTH, 7'd2, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PEEK, 0, 127, 1'b1,
			'{NO_WORD, lfs_pkg::ST_BAD_DEPTH, 7'd2, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PEEK, 0, 2, 1'b1,
			'{32'h7FFFFFFF, lfs_pkg::ST_OK, 7'd2, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PEEK, 0, 1, 1'b0, '0);
		add_op(ACT_NOP, 5, 1, 1'b1, '{NO_WORD, lfs_pkg::ST_OK, 7'd2, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PUSH, 32'hFFFFFFFF, 0, 1'b0, '0);
		add_op(lfs_pkg::ACT_PUSH, 0, 0, 1'b0, '0);
		add_op(lfs_pkg::ACT_PEEK, 0, 3, 1'b0, '0);
		repeat (4) add_op(lfs_pkg::ACT_POP, 0, 0, 1'b0, '0);
		add_op(lfs_pkg::ACT_POP, 0, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_UNDERFLOW, 7'd0, 1'b1, 1'b0});
		// capacity of one
		add_limit(7'd1);
		add_op(lfs_pkg::ACT_PUSH, 32'h12345678, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OK, 7'd1, 1'b0, 1'b1});
		add_op(lfs_pkg::ACT_PUSH, 32'h55AA55AA, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OVERFLOW, 7'd1, 1'b0, 1'b1});
		// zero capacity, lowered below the count
		add_limit(7'd0);
		add_op(lfs_pkg::ACT_PUSH, 32'h0F0F0F0F, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OVERFLOW, 7'd1, 1'b0, 1'b1});
		add_op(lfs_pkg::ACT_POP, 0, 0, 1'b0, '0);
		add_op(lfs_pkg::ACT_PUSH, 32'h0F0F0F0F, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OVERFLOW, 7'd0, 1'b1, 1'b1});
		// limit above the depth saturates
		add_limit(7'd127);
		add_op(lfs_pkg::ACT_PUSH, 32'h2A, 0, 1'b1,
			'{NO_WORD, lfs_pkg::ST_OK, 7'd1, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_PEEK, 0, 64, 1'b1,
			'{NO_WORD, lfs_pkg::ST_BAD_DEPTH, 7'd1, 1'b0, 1'b0});
		add_op(lfs_pkg::ACT_POP, 0, 0, 1'b0, '0);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script_rows[i]) begin
			if (script_rows[i].is_limit)
				set_limit(script_rows[i].limit);
			else
				send_op(script_rows[i].action, script_rows[i].word, script_rows[i].depth,
					script_rows[i].typed, script_rows[i].exp);
		end

		// random phases: filling, draining and mixed, each under its own limit
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			lim = lfs_pkg::CNT_W'(phase_limits[ph]);
			if (ph == 5)
				lim = lfs_pkg::CNT_W'($urandom_range(1, 127));
			set_limit(lim);
			no_idle = (ph % 4 == 3);
			case (ph % 3)
				0: begin
					push_cut = 80;
					pop_cut = 88;
				end
				1: begin
					push_cut = 25;
					pop_cut = 75;
				end
				default: begin
					push_cut = 45;
					pop_cut = 72;
				end
			endcase
			for (int n = 0; n < PHASE_OPS; n++) begin
				r = $urandom_range(0, 99);
				if (r < push_cut)
					act = lfs_pkg::ACT_PUSH;
				else if (r < pop_cut)
					act = lfs_pkg::ACT_POP;
				else if (r < 97)
					act = lfs_pkg::ACT_PEEK;
				else
					act = ACT_NOP;
				r = $urandom_range(0, 9);
				if (r == 0)
					word = 32'h7FFFFFFF;
				else if (r == 1)
					word = 32'h80000000;
				else
					word = $urandom;
				// mostly valid depths, sometimes anything the field holds
				if (stack_fill > 0 && $urandom_range(0, 3) != 0)
					depth = lfs_pkg::CNT_W'($urandom_range(1, stack_fill));
				else
					depth = lfs_pkg::CNT_W'($urandom_range(0, 127));
				send_op(act, word, depth, 1'b0, '0);
			end
		end

		req_ch.valid = 1'b0;
		no_idle = 1'b0;
		wait_drained();
		repeat (10) @(negedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("lifo_stack_with_peek: match");
		else
			$display("lifo_stack_with_peek: mismatch");
		$finish;
	end

endmodule
